// ===== rtl/core/lgmt_pkg.sv =====
package lgmt_pkg;

  localparam int unsigned GROUPS_DEF    = 16;
  localparam int unsigned ADDRESSES_DEF = 64;

  localparam int unsigned S_TDATA_W = 112;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 16;

  localparam logic [4:0] ALL_GROUPS_CODE = 5'd16;

  localparam logic [1:0] KIND_SHORT = 2'd0;
  localparam logic [1:0] KIND_GROUP = 2'd1;

  typedef enum logic [3:0] {
    OP_CLEAR  = 4'd0,
    OP_MERGE  = 4'd1,
    OP_SEED   = 4'd2,
    OP_PICK   = 4'd3,
    OP_FORGET = 4'd4,
    OP_MOVE   = 4'd5,
    OP_COVER  = 4'd6,
    OP_ADD    = 4'd7,
    OP_REMOVE = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    MS_NONE       = 2'd0,
    MS_UPDATED    = 2'd1,
    MS_UNV_ADD    = 2'd2,
    MS_UNV_REMOVE = 2'd3
  } map_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_PICK_RD,
    ST_PICK_LD,
    ST_PICK_RUN,
    ST_TRK_SRC,
    ST_TRK_LD,
    ST_TRK_WR,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic clr;
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic       done;
    logic       found;
    logic [5:0] addr;
  } pick_res_t;

endpackage

// ===== rtl/core/lgmt_mem.sv =====
module lgmt_mem #(
  parameter int unsigned GROUPS    = lgmt_pkg::GROUPS_DEF,
  parameter int unsigned ADDRESSES = lgmt_pkg::ADDRESSES_DEF,
  localparam int unsigned GW = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lgmt_pkg::mem_ctl_t   ctl_i,
  input  logic [GW-1:0]        wr_idx_i,
  input  logic [ADDRESSES-1:0] wr_data_i,
  input  logic [GW-1:0]        rd_idx_i,
  output logic [ADDRESSES-1:0] rd_data_o
);
  import lgmt_pkg::*;

  logic [ADDRESSES-1:0] mem_q [GROUPS];
  logic [GROUPS-1:0]    vld_q;
  logic [ADDRESSES-1:0] rd_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_idx_i];
    end
  end

  // An entry that was never written since the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clr) begin
        vld_q <= '0;
      end else if (ctl_i.wr_en) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_idx_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/core/lgmt_pick.sv =====
module lgmt_pick #(
  parameter int unsigned ADDRESSES = lgmt_pkg::ADDRESSES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ADDRESSES-1:0]  word_i,
  output lgmt_pkg::pick_res_t   res_o
);
  import lgmt_pkg::*;

  localparam int unsigned NCH = (ADDRESSES + 7) / 8;
  localparam int unsigned CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned PW  = NCH * 8;

  logic            busy_q;
  logic [PW-1:0]   word_q;
  logic [CW-1:0]   cnt_q;
  pick_res_t       res_q;
  logic [7:0]      chunk;
  logic [2:0]      pos;

  assign chunk = word_q[{cnt_q, 3'b000} +: 8];

  always_comb begin
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (chunk[i]) begin
        pos = 3'(i);
      end
    end
  end

  // One byte of the group word is examined per cycle, lowest byte first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      res_q  <= '0;
      cnt_q  <= '0;
      word_q <= '0;
    end else begin
      if (start_i) begin
        busy_q     <= 1'b1;
        word_q     <= PW'(word_i);
        cnt_q      <= '0;
        res_q.done <= 1'b0;
      end else if (busy_q) begin
        if (chunk != 8'd0) begin
          busy_q      <= 1'b0;
          res_q.done  <= 1'b1;
          res_q.found <= 1'b1;
          res_q.addr  <= 6'({cnt_q, pos});
        end else if (cnt_q == CW'(NCH - 1)) begin
          busy_q      <= 1'b0;
          res_q.done  <= 1'b1;
          res_q.found <= 1'b0;
          res_q.addr  <= 6'd0;
        end else begin
          cnt_q      <= cnt_q + 1'b1;
          res_q.done <= 1'b0;
        end
      end else begin
        res_q.done <= 1'b0;
      end
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/lighting_group_membership_table.sv =====
// Lighting group membership table.
// Keeps one membership bitmap per lighting group in a one-port-read,
// one-port-write memory plus a register of verified groups. Each item on the
// slave stream is one command; exactly one result item leaves on the master
// stream for every command accepted.
// s_axis_tdata carries the command fields, s_axis_tuser the target kind.
// m_axis_tdata carries picked address, found, changed, map status, covered.
// Path per item, from accept to result valid:
//   clear, unused opcodes and commands with out-of-range operands go straight
//   to the finish step; merge, seed, forget, move and coverage sweep every
//   group entry through the memory read port, one entry per cycle; pick reads
//   its group, then scans it a byte per cycle; add and remove to group pass
//   through the source, load and write steps as their target kind needs.
// A new item is accepted on the cycle after the previous result is loaded.
// The result sits in an output register, so the next command proceeds while
// it waits; a stalled receiver holds the block only when a second result is
// ready to be loaded. Reset empties all groups, clears the verified mask and
// drops any pending result; the block is ready on the first cycle after it.
module lighting_group_membership_table #(
  parameter int unsigned GROUPS    = lgmt_pkg::GROUPS_DEF,
  parameter int unsigned ADDRESSES = lgmt_pkg::ADDRESSES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // opcode[3:0] group[8:4] address[14:9] other_address[20:15]
  // target_number[26:21] group_mask[42:27] observed[106:43]
  // complete_flag[107], zero padding above.
  input  logic [lgmt_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // target_kind[1:0]
  input  logic [lgmt_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // picked_address[5:0] found[6] changed[7] map_status[9:8] covered[10],
  // zero padding above.
  output logic [lgmt_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import lgmt_pkg::*;

  localparam int unsigned GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  // Command fields on the input stream.
  logic [3:0]  in_opcode;
  logic [4:0]  in_group;
  logic [5:0]  in_address;
  logic [5:0]  in_other;
  logic [5:0]  in_tnum;
  logic [15:0] in_gmask;
  logic [63:0] in_observed;
  logic        in_complete;
  logic [1:0]  in_kind;
  op_e         in_op;

  assign in_opcode   = s_axis_tdata_i[3:0];
  assign in_group    = s_axis_tdata_i[8:4];
  assign in_address  = s_axis_tdata_i[14:9];
  assign in_other    = s_axis_tdata_i[20:15];
  assign in_tnum     = s_axis_tdata_i[26:21];
  assign in_gmask    = s_axis_tdata_i[42:27];
  assign in_observed = s_axis_tdata_i[106:43];
  assign in_complete = s_axis_tdata_i[107];
  assign in_kind     = s_axis_tuser_i[1:0];
  assign in_op       = op_e'(in_opcode);

  state_e               state_q, state_d;
  op_e                  op_q;
  logic [4:0]           grp_q;
  logic [5:0]           addr_q;
  logic [5:0]           oth_q;
  logic [5:0]           tnum_q;
  logic [1:0]           kind_q;
  logic [15:0]          gmask_q;
  logic [ADDRESSES-1:0] obs_q;
  logic [GROUPS-1:0]    verified_q;
  logic [GW-1:0]        rd_idx_q;
  logic                 rd_busy_q;
  logic                 ph_vld_q;
  logic [GW-1:0]        ph_idx_q;
  logic [ADDRESSES-1:0] known_q;
  logic [ADDRESSES-1:0] aff_q;
  logic [5:0]           pick_addr_q;
  logic                 found_q;
  logic                 changed_q;
  map_status_e          status_q;
  logic                 m_tvalid_q;
  logic [M_TDATA_W-1:0] m_tdata_q;

  logic                 accept;
  logic                 in_addr_ok;
  logic                 in_oth_ok;
  logic                 in_grp_ok;
  logic                 in_ok;
  logic                 out_free;
  logic                 grp_all;
  logic [GW-1:0]        grp_idx;
  logic [GW-1:0]        src_idx;
  logic                 tnum_ok;
  logic                 src_ok;
  logic                 src_verified;
  logic                 covered;
  logic [M_TDATA_W-1:0] res_word;
  logic [ADDRESSES-1:0] abit;
  logic [ADDRESSES-1:0] obit;
  logic [ADDRESSES-1:0] tbit;
  logic [GROUPS-1:0]    dest_oh;

  mem_ctl_t             mem_ctl;
  logic [GW-1:0]        mem_rd_idx;
  logic [GW-1:0]        mem_wr_idx;
  logic [ADDRESSES-1:0] mem_wr_data;
  logic [ADDRESSES-1:0] mem_rd_data;
  logic [ADDRESSES-1:0] new_word;
  logic                 sw_hit;
  logic                 pick_start;
  pick_res_t            pick_res;
  logic                 ver_clr;
  logic                 status_set;
  map_status_e          status_val;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_tvalid_q || m_axis_tready_i;

  assign in_addr_ok = {1'b0, in_address} < 7'(ADDRESSES);
  assign in_oth_ok  = {1'b0, in_other} < 7'(ADDRESSES);
  assign in_grp_ok  = in_group < 5'(GROUPS);

  always_comb begin
    unique case (in_op)
      OP_MERGE:         in_ok = in_addr_ok;
      OP_SEED:          in_ok = in_addr_ok && in_grp_ok;
      OP_PICK:          in_ok = in_grp_ok;
      OP_FORGET:        in_ok = in_addr_ok && (in_grp_ok || in_group == ALL_GROUPS_CODE);
      OP_MOVE:          in_ok = in_addr_ok && in_oth_ok && (in_address != in_other);
      OP_ADD, OP_REMOVE: in_ok = in_grp_ok;
      default:          in_ok = 1'b1;
    endcase
  end

  assign grp_all      = (grp_q == ALL_GROUPS_CODE);
  assign grp_idx      = grp_q[GW-1:0];
  assign src_idx      = tnum_q[GW-1:0];
  assign tnum_ok      = {1'b0, tnum_q} < 7'(ADDRESSES);
  assign src_ok       = tnum_q < 6'(GROUPS);
  assign src_verified = verified_q[src_idx];

  for (genvar a = 0; a < ADDRESSES; a++) begin : g_addr_dec
    assign abit[a] = (addr_q == 6'(a));
    assign obit[a] = (oth_q == 6'(a));
    assign tbit[a] = (tnum_q == 6'(a));
  end

  for (genvar g = 0; g < GROUPS; g++) begin : g_grp_dec
    assign dest_oh[g] = (grp_q == 5'(g));
  end

  lgmt_mem #(
    .GROUPS    (GROUPS),
    .ADDRESSES (ADDRESSES)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .wr_idx_i  (mem_wr_idx),
    .wr_data_i (mem_wr_data),
    .rd_idx_i  (mem_rd_idx),
    .rd_data_o (mem_rd_data)
  );

  lgmt_pick #(
    .ADDRESSES (ADDRESSES)
  ) u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pick_start),
    .word_i  (mem_rd_data),
    .res_o   (pick_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!in_ok) begin
            state_d = ST_FIN;
          end else begin
            unique case (in_op)
              OP_MERGE, OP_SEED, OP_FORGET, OP_MOVE, OP_COVER: state_d = ST_SWEEP;
              OP_PICK:           state_d = ST_PICK_RD;
              OP_ADD, OP_REMOVE: state_d = ST_TRK_SRC;
              default:           state_d = ST_FIN;
            endcase
          end
        end
      end
      ST_SWEEP: begin
        if (ph_vld_q && ph_idx_q == GW'(GROUPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_PICK_RD:  state_d = ST_PICK_LD;
      ST_PICK_LD:  state_d = ST_PICK_RUN;
      ST_PICK_RUN: begin
        if (pick_res.done) begin
          state_d = ST_FIN;
        end
      end
      ST_TRK_SRC: begin
        if (kind_q == KIND_SHORT && tnum_ok) begin
          state_d = ST_TRK_WR;
        end else if (kind_q == KIND_GROUP && src_ok && src_verified) begin
          state_d = ST_TRK_LD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_TRK_LD: state_d = ST_TRK_WR;
      ST_TRK_WR: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl     = '0;
    mem_rd_idx  = '0;
    mem_wr_idx  = '0;
    mem_wr_data = '0;
    new_word    = '0;
    sw_hit      = 1'b0;
    pick_start  = 1'b0;
    ver_clr     = 1'b0;
    status_set  = 1'b0;
    status_val  = MS_NONE;
    unique case (state_q)
      ST_IDLE: begin
        mem_ctl.clr = accept && (in_op == OP_CLEAR);
      end
      ST_SWEEP: begin
        // Entry n is read while entry n-1 is written back.
        mem_ctl.rd_en = rd_busy_q;
        mem_rd_idx    = rd_idx_q;
        mem_wr_idx    = ph_idx_q;
        if (ph_vld_q) begin
          unique case (op_q)
            OP_MERGE: begin
              mem_ctl.wr_en = gmask_q[ph_idx_q];
              mem_wr_data   = mem_rd_data | abit;
            end
            OP_SEED: begin
              mem_ctl.wr_en = (grp_idx == ph_idx_q);
              mem_wr_data   = mem_rd_data | abit;
            end
            OP_FORGET: begin
              sw_hit        = (grp_all || grp_idx == ph_idx_q) && |(mem_rd_data & abit);
              mem_ctl.wr_en = sw_hit;
              mem_wr_data   = mem_rd_data & ~abit;
            end
            OP_MOVE: begin
              sw_hit        = |(mem_rd_data & abit);
              mem_ctl.wr_en = sw_hit;
              mem_wr_data   = (mem_rd_data & ~abit) | obit;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PICK_RD: begin
        mem_ctl.rd_en = 1'b1;
        mem_rd_idx    = grp_idx;
      end
      ST_PICK_LD: begin
        pick_start = 1'b1;
      end
      ST_PICK_RUN: begin
      end
      ST_TRK_SRC: begin
        if (kind_q == KIND_SHORT) begin
          if (tnum_ok) begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_idx    = grp_idx;
          end
        end else if (kind_q == KIND_GROUP && src_ok) begin
          if (src_verified) begin
            mem_ctl.rd_en = 1'b1;
            mem_rd_idx    = src_idx;
          end else begin
            // The source group is not fully known, so the destination no longer is.
            ver_clr    = 1'b1;
            status_set = 1'b1;
            if (op_q == OP_REMOVE) begin
              mem_ctl.wr_en = 1'b1;
              mem_wr_idx    = grp_idx;
              mem_wr_data   = '0;
              status_val    = MS_UNV_REMOVE;
            end else begin
              status_val = MS_UNV_ADD;
            end
          end
        end
      end
      ST_TRK_LD: begin
        mem_ctl.rd_en = 1'b1;
        mem_rd_idx    = grp_idx;
      end
      ST_TRK_WR: begin
        new_word      = (op_q == OP_ADD) ? (mem_rd_data | aff_q) : (mem_rd_data & ~aff_q);
        mem_ctl.wr_en = 1'b1;
        mem_wr_idx    = grp_idx;
        mem_wr_data   = new_word;
        status_set    = 1'b1;
        status_val    = (new_word != mem_rd_data) ? MS_UPDATED : MS_NONE;
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  assign covered  = (op_q == OP_COVER) && ((known_q & ~obs_q) == '0);
  assign res_word = M_TDATA_W'({covered, status_q, changed_q, found_q, pick_addr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      verified_q <= '0;
      rd_busy_q  <= 1'b0;
      rd_idx_q   <= '0;
      ph_vld_q   <= 1'b0;
      ph_idx_q   <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        rd_busy_q <= 1'b1;
        rd_idx_q  <= '0;
        ph_vld_q  <= 1'b0;
        if (in_op == OP_CLEAR) begin
          verified_q <= in_complete ? '1 : '0;
        end
      end else if (state_q == ST_SWEEP) begin
        ph_vld_q <= rd_busy_q;
        ph_idx_q <= rd_idx_q;
        if (rd_busy_q) begin
          if (rd_idx_q == GW'(GROUPS - 1)) begin
            rd_busy_q <= 1'b0;
          end else begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
        end
      end
      if (ver_clr) begin
        verified_q <= verified_q & ~dest_oh;
      end
      if (state_q == ST_FIN && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= in_op;
      grp_q       <= in_group;
      addr_q      <= in_address;
      oth_q       <= in_other;
      tnum_q      <= in_tnum;
      kind_q      <= in_kind;
      gmask_q     <= in_gmask;
      obs_q       <= in_observed[ADDRESSES-1:0];
      known_q     <= '0;
      pick_addr_q <= 6'd0;
      found_q     <= 1'b0;
      changed_q   <= 1'b0;
      status_q    <= MS_NONE;
    end else begin
      if (state_q == ST_SWEEP && ph_vld_q) begin
        known_q   <= known_q | mem_rd_data;
        changed_q <= changed_q | sw_hit;
      end
      if (state_q == ST_TRK_SRC) begin
        aff_q <= tbit;
      end else if (state_q == ST_TRK_LD) begin
        aff_q <= mem_rd_data;
      end
      if (status_set) begin
        status_q <= status_val;
      end
      if (state_q == ST_PICK_RUN && pick_res.done) begin
        found_q     <= pick_res.found;
        pick_addr_q <= pick_res.addr;
      end
    end
    if (state_q == ST_FIN && out_free) begin
      m_tdata_q <= res_word;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  a_no_wr_rd_same_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl.wr_en && mem_ctl.rd_en) |-> (mem_wr_idx != mem_rd_idx))
    else $error("memory write and read hit the same entry in one cycle");

  a_no_clr_with_wr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.clr |-> !mem_ctl.wr_en)
    else $error("table clear collides with a write");

  a_accept_sweep_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !ph_vld_q)
    else $error("item accepted while a sweep write is pending");

  a_result_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_FIN))
    else $error("result raised outside the finish step");

  a_pick_done_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_res.done |-> (state_q == ST_PICK_RUN))
    else $error("pick result arrived while not waiting for it");

endmodule

// ===== tb/sv/lgmt_result_checker.sv =====
module lgmt_result_checker #(
  parameter int unsigned GROUPS    = lgmt_pkg::GROUPS_DEF,
  parameter int unsigned ADDRESSES = lgmt_pkg::ADDRESSES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  input  logic [lgmt_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic [lgmt_pkg::S_TUSER_W-1:0] s_tuser_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  input  logic [lgmt_pkg::M_TDATA_W-1:0] m_tdata_i,
  output int unsigned                    outstanding_o,
  output int unsigned                    checked_o,
  output int unsigned                    fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import lgmt_pkg::*;

  typedef struct packed {
    logic [3:0]  pad;
    logic        complete;
    logic [63:0] observed;
    logic [15:0] gmask;
    logic [5:0]  tnum;
    logic [5:0]  other;
    logic [5:0]  address;
    logic [4:0]  group;
    logic [3:0]  opcode;
  } command_t;

  typedef struct packed {
    logic [4:0] pad;
    logic       covered;
    logic [1:0] status;
    logic       changed;
    logic       found;
    logic [5:0] picked;
  } result_t;

  logic [63:0] member_map [GROUPS];
  logic [15:0] verified_mask;
  result_t     pending_results [$];
  int unsigned checked_count;
  int unsigned fail_count;

  assign outstanding_o = pending_results.size();
  assign checked_o     = checked_count;
  assign fail_count_o  = fail_count;

  task automatic track_group_command(input logic is_add, input logic [4:0] dest,
                                     input logic [1:0] kind, input logic [5:0] src,
                                     output logic [1:0] status);
    logic [63:0] affected;
    logic [63:0] prior;
    status = MS_NONE;
    if (dest >= GROUPS) return;
    if (kind == KIND_SHORT) begin
      if (src >= ADDRESSES) return;
      affected = 64'd1 << src;
    end else if (kind == KIND_GROUP && src < GROUPS) begin
      if (!verified_mask[src]) begin
        verified_mask[dest] = 1'b0;
        if (is_add) begin
          status = MS_UNV_ADD;
        end else begin
          member_map[dest] = '0;
          status = MS_UNV_REMOVE;
        end
        return;
      end
      affected = member_map[src];
    end else begin
      return;
    end
    prior = member_map[dest];
    member_map[dest] = is_add ? (prior | affected) : (prior & ~affected);
    status = (member_map[dest] == prior) ? MS_NONE : MS_UPDATED;
  endtask

  task automatic apply_command(input command_t c, input logic [1:0] kind,
                               output result_t r);
    logic [63:0] src_bit;
    logic [63:0] to_bit;
    logic [63:0] known;
    int          g;
    int          a;
    r        = '0;
    src_bit  = 64'd1 << c.address;
    to_bit   = 64'd1 << c.other;
    known    = '0;
    case (c.opcode)
      OP_CLEAR: begin
        for (g = 0; g < GROUPS; g++) member_map[g] = '0;
        verified_mask = c.complete ? ({16{1'b1}} >> (16 - GROUPS)) : '0;
      end
      OP_MERGE: begin
        if (c.address < ADDRESSES)
          for (g = 0; g < GROUPS; g++)
            if (c.gmask[g]) member_map[g] |= src_bit;
      end
      OP_SEED: begin
        if (c.group < GROUPS && c.address < ADDRESSES) member_map[c.group] |= src_bit;
      end
      OP_PICK: begin
        if (c.group < GROUPS)
          for (a = ADDRESSES - 1; a >= 0; a--)
            if (member_map[c.group][a]) begin
              r.picked = 6'(a);
              r.found  = 1'b1;
            end
      end
      OP_FORGET: begin
        if (c.address < ADDRESSES && (c.group < GROUPS || c.group == ALL_GROUPS_CODE))
          for (g = 0; g < GROUPS; g++)
            if ((c.group == ALL_GROUPS_CODE || g == c.group) &&
                (member_map[g] & src_bit) != 0) begin
              member_map[g] &= ~src_bit;
              r.changed = 1'b1;
            end
      end
      OP_MOVE: begin
        if (c.address < ADDRESSES && c.other < ADDRESSES && c.address != c.other)
          for (g = 0; g < GROUPS; g++)
            if ((member_map[g] & src_bit) != 0) begin
              member_map[g] = (member_map[g] & ~src_bit) | to_bit;
              r.changed = 1'b1;
            end
      end
      OP_COVER: begin
        for (g = 0; g < GROUPS; g++) known |= member_map[g];
        r.covered = ((known & ~c.observed) == 0);
      end
      OP_ADD, OP_REMOVE: begin
        track_group_command(c.opcode == OP_ADD, c.group, kind, c.tnum, r.status);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int g = 0; g < GROUPS; g++) member_map[g] = '0;
      verified_mask = '0;
      pending_results.delete();
      checked_count = 0;
      fail_count    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i);
        if (pending_results.size() == 0) begin
          $error("Result item %0h arrived with no command waiting", m_tdata_i);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("picked_address", 16'(want.picked), 16'(got.picked));
          check_field("found", 16'(want.found), 16'(got.found));
          check_field("changed", 16'(want.changed), 16'(got.changed));
          check_field("map_status", 16'(want.status), 16'(got.status));
          check_field("covered", 16'(want.covered), 16'(got.covered));
          check_field("padding", 16'(want.pad), 16'(got.pad));
          checked_count++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        apply_command(command_t'(s_tdata_i), s_tuser_i, want);
        pending_results.push_back(want);
      end
    end
  end

  final begin
    if (pending_results.size() != 0)
      $error("%0d expected results never arrived", pending_results.size());
  end

endmodule

// ===== tb/sv/tb_lighting_group_membership_table.sv =====
module tb_lighting_group_membership_table;

  timeunit 1ns;
  timeprecision 1ps;

  import lgmt_pkg::*;

  localparam logic [3:0] OP_UNUSED_LO = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam logic [1:0] KIND_OTHER    = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam logic [63:0] SCAN_ALL  = {64{1'b1}};
  localparam logic [63:0] SCAN_NONE = '0;
  localparam int unsigned RANDOM_PER_PHASE = 610;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;

  int unsigned outstanding;
  int unsigned checked;
  int unsigned fail_count;
  int unsigned sender_idle_pct = 16;
  int unsigned receiver_idle_pct = 57;
  int unsigned commands_sent = 0;

  lighting_group_membership_table u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  lgmt_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid_i),
    .s_tready_i    (s_axis_tready_o),
    .s_tdata_i     (s_axis_tdata_i),
    .s_tuser_i     (s_axis_tuser_i),
    .m_tvalid_i    (m_axis_tvalid_o),
    .m_tready_i    (m_axis_tready_i),
    .m_tdata_i     (m_axis_tdata_o),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .fail_count_o  (fail_count)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= receiver_idle_pct);
  end

  initial begin
    #4_000_000;
    $display("lighting_group_membership_table test failed");
    $finish;
  end

  task automatic send_cmd(input logic [3:0] op, input logic [4:0] group,
                          input logic [5:0] address, input logic [5:0] other,
                          input logic [1:0] kind, input logic [5:0] tnum,
                          input logic [15:0] gmask, input logic [63:0] observed,
                          input logic complete);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, complete, observed, gmask, tnum, other, address, group, op};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    commands_sent++;
  endtask

  function automatic logic [5:0] random_address();
    return ($urandom_range(99) < 60) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
  endfunction

  task automatic send_random_cmd();
    int unsigned roll;
    logic [3:0]  op;
    logic [4:0]  group;
    logic [1:0]  kind;
    logic [5:0]  tnum;
    logic [63:0] observed;
    roll = $urandom_range(99);
    if (roll < 3)       op = OP_CLEAR;
    else if (roll < 20) op = OP_MERGE;
    else if (roll < 38) op = OP_SEED;
    else if (roll < 50) op = OP_PICK;
    else if (roll < 60) op = OP_FORGET;
    else if (roll < 68) op = OP_MOVE;
    else if (roll < 76) op = OP_COVER;
    else if (roll < 86) op = OP_ADD;
    else if (roll < 96) op = OP_REMOVE;
    else                op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    group = ($urandom_range(99) < 90) ? 5'($urandom_range(15)) : 5'($urandom_range(31, 16));
    if (op == OP_FORGET && $urandom_range(3) == 0) group = ALL_GROUPS_CODE;
    roll = $urandom_range(99);
    if (roll < 45)      kind = KIND_SHORT;
    else if (roll < 90) kind = KIND_GROUP;
    else                kind = $urandom_range(1) ? KIND_OTHER : KIND_RESERVED;
    if (kind == KIND_GROUP && $urandom_range(99) < 90) tnum = 6'($urandom_range(15));
    else tnum = random_address();
    case ($urandom_range(3))
      0:       observed = SCAN_ALL;
      1:       observed = SCAN_NONE;
      2:       observed = {$urandom, $urandom} | 64'hFF;
      default: observed = {$urandom, $urandom};
    endcase
    send_cmd(op, group, random_address(), random_address(), kind, tnum,
             16'($urandom & $urandom), observed, 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(OP_PICK, 5'd0, 6'd0, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_COVER, 5'd0, 6'd0, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_SEED, 5'd0, 6'd63, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_SEED, 5'd15, 6'd0, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_SEED, 5'd31, 6'd1, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_PICK, 5'd0, 6'd0, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_PICK, 5'd15, 6'd0, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_PICK, 5'd31, 6'd0, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_MERGE, 5'd0, 6'd5, 6'd0, KIND_SHORT, 6'd0, 16'hFFFF, SCAN_NONE, 1'b0);
    send_cmd(OP_FORGET, 5'd3, 6'd5, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_FORGET, 5'd3, 6'd5, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_FORGET, ALL_GROUPS_CODE, 6'd5, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_MOVE, 5'd0, 6'd63, 6'd62, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_MOVE, 5'd0, 6'd62, 6'd62, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_COVER, 5'd0, 6'd0, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_ALL, 1'b0);
    send_cmd(OP_COVER, 5'd0, 6'd0, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_ADD, 5'd2, 6'd0, 6'd0, KIND_SHORT, 6'd63, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_ADD, 5'd2, 6'd0, 6'd0, KIND_SHORT, 6'd63, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_ADD, 5'd4, 6'd0, 6'd0, KIND_GROUP, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_REMOVE, 5'd2, 6'd0, 6'd0, KIND_GROUP, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_CLEAR, 5'd0, 6'd0, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b1);
    send_cmd(OP_SEED, 5'd1, 6'd7, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_ADD, 5'd4, 6'd0, 6'd0, KIND_GROUP, 6'd1, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_REMOVE, 5'd4, 6'd0, 6'd0, KIND_GROUP, 6'd1, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_ADD, 5'd4, 6'd0, 6'd0, KIND_OTHER, 6'd1, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_REMOVE, 5'd4, 6'd0, 6'd0, KIND_RESERVED, 6'd1, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_ADD, 5'd4, 6'd0, 6'd0, KIND_GROUP, 6'd40, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_ADD, 5'd17, 6'd0, 6'd0, KIND_SHORT, 6'd3, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_UNUSED_LO, 5'd0, 6'd0, 6'd0, KIND_SHORT, 6'd0, 16'hFFFF, SCAN_ALL, 1'b1);
    send_cmd(OP_UNUSED_HI, 5'd0, 6'd0, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);
    send_cmd(OP_CLEAR, 5'd0, 6'd0, 6'd0, KIND_SHORT, 6'd0, 16'h0, SCAN_NONE, 1'b0);

    repeat (RANDOM_PER_PHASE) send_random_cmd();
    sender_idle_pct   = 57;
    receiver_idle_pct = 16;
    repeat (RANDOM_PER_PHASE) send_random_cmd();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) send_random_cmd();
    s_axis_tvalid_i <= 1'b0;

    do @(negedge clk_i); while (outstanding != 0);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d commands under three idle mixes; %0d result items checked.",
             commands_sent, checked);
    if (fail_count == 0) begin
      $display("lighting_group_membership_table test passed");
    end else begin
      $display("lighting_group_membership_table test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lgmt_pkg.sv
rtl/core/lgmt_mem.sv
rtl/core/lgmt_pick.sv
rtl/core/lighting_group_membership_table.sv
tb/sv/lgmt_result_checker.sv
tb/sv/tb_lighting_group_membership_table.sv
